/* design/assert_macros.svh */
// assertion helpers, empty under synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHT_ASSERT_RST(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHT_ASSERT(label, clk, rst_n, prop, msg)
`define CHT_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

/* design/cht_pkg.sv */
package cht_pkg;
	localparam int NumBucketsDef = 256;
	localparam int MaxEntriesDef = 256;
	localparam int KeyBytesDef = 8;
	localparam int ValueWidthDef = 32;
	localparam int CfgW = 9;
	localparam int KeyW = 64;
	localparam int KlenW = 4;
	localparam int ValW = 32;
	localparam int VlenW = 16;
	localparam int HashMult = 32;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DUP      = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;
endpackage

/* design/cht_hash.sv */
// bucket hash, one key byte at a time, remainder by repeated subtraction
module cht_hash #(
	parameter int NUM_BUCKETS = cht_pkg::NumBucketsDef,
	parameter int KEY_BYTES = cht_pkg::KeyBytesDef,
	parameter int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [cht_pkg::KeyW-1:0] key,
	input  logic [3:0]               len,
	input  logic [16:0]              modv,
	output logic                     done,
	output logic [BW-1:0]            bucket
);
	import cht_pkg::*;

	typedef enum logic [1:0] {H_IDLE, H_LOAD, H_RED, H_DONE} hst_t;
	hst_t st_q;
	logic [3:0] idx_q;
	logic [27:0] acc_q;
	logic [3:0] shift_q;
	logic [7:0] byte_sel;

	assign byte_sel = key[{idx_q[2:0], 3'b000} +: 8];
	assign done = (st_q == H_DONE);
	assign bucket = BW'(acc_q);

	// load a key byte, then reduce by subtracting shifted modulus, one bit position per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= H_IDLE;
			idx_q <= '0;
			acc_q <= '0;
			shift_q <= '0;
		end else begin
			case (st_q)
				H_IDLE: begin
					if (start) begin
						idx_q <= '0;
						acc_q <= '0;
						st_q <= (len == 4'd0) ? H_DONE : H_LOAD;
					end
				end
				H_LOAD: begin
					if (idx_q == 4'd0) acc_q <= 28'(byte_sel);
					else acc_q <= {acc_q[22:0], 5'b0} + 28'(byte_sel);
					idx_q <= idx_q + 4'd1;
					shift_q <= 4'd11;
					st_q <= H_RED;
				end
				H_RED: begin
					if (acc_q >= (28'(modv) << shift_q))
						acc_q <= acc_q - (28'(modv) << shift_q);
					if (shift_q == 4'd0)
						st_q <= (idx_q == len) ? H_DONE : H_LOAD;
					else
						shift_q <= shift_q - 4'd1;
				end
				H_DONE: st_q <= H_IDLE;
				default: st_q <= H_IDLE;
			endcase
		end
	end
endmodule

/* design/cht_core.sv */
// table memories and the chain walk sequencer
module cht_core #(
	parameter int NUM_BUCKETS = cht_pkg::NumBucketsDef,
	parameter int MAX_ENTRIES = cht_pkg::MaxEntriesDef,
	parameter int VALUE_WIDTH = cht_pkg::ValueWidthDef,
	parameter int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
	parameter int EW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                cmd,
	input  logic [cht_pkg::KeyW-1:0]  key,
	input  logic [3:0]                len,
	input  logic [cht_pkg::ValW-1:0]  value,
	input  logic [cht_pkg::VlenW-1:0] value_len,
	input  logic                      hash_done,
	input  logic [BW-1:0]             bucket,
	output logic                      busy,
	output logic                      res_valid,
	output logic [1:0]                res_status,
	output logic [cht_pkg::ValW-1:0]  res_value,
	output logic [cht_pkg::VlenW-1:0] res_len,
	output logic                      init_done
);
	import cht_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int SW = (NUM_BUCKETS > MAX_ENTRIES) ? BW + 1 : AW + 1;
	localparam logic [EW-1:0] NIL = EW'(MAX_ENTRIES);

	typedef enum logic [3:0] {
		C_INIT, C_IDLE, C_HASH, C_HEAD, C_RD, C_CMP, C_INS, C_DEL, C_FREE, C_OUT
	} cst_t;

	logic [EW-1:0] heads_mem [NUM_BUCKETS];
	logic [NUM_BUCKETS-1:0] head_vld_q;
	logic [KeyW-1:0] keys_mem [MAX_ENTRIES];
	logic [KlenW-1:0] klen_mem [MAX_ENTRIES];
	logic [VALUE_WIDTH-1:0] vals_mem [MAX_ENTRIES];
	logic [VlenW-1:0] vlen_mem [MAX_ENTRIES];
	logic [EW-1:0] link_mem [MAX_ENTRIES];

	cst_t st_q;
	logic [SW-1:0] init_q;
	logic [BW-1:0] bkt_q;
	logic [EW-1:0] cur_q, prev_q, free_q, hit_q, steps_q;
	logic [EW-1:0] head_rd_q;
	logic [KeyW-1:0] key_rd_q;
	logic [KlenW-1:0] klen_rd_q;
	logic [VALUE_WIDTH-1:0] val_rd_q;
	logic [VlenW-1:0] vlen_rd_q;
	logic [EW-1:0] link_rd_q;
	logic [EW-1:0] head_val;
	logic [AW-1:0] rd_addr, wr_addr;
	logic link_we, ent_we;
	logic [EW-1:0] link_wd;
	logic [1:0] sts_q;
	logic [ValW-1:0] fv_q;
	logic [VlenW-1:0] fl_q;

	assign head_val = head_vld_q[bkt_q] ? head_rd_q : NIL;
	assign busy = (st_q != C_IDLE);
	assign init_done = (st_q != C_INIT);
	assign res_valid = (st_q == C_OUT);
	assign res_status = sts_q;
	assign res_value = fv_q;
	assign res_len = fl_q;

	always_ff @(posedge clk) begin
		head_rd_q <= heads_mem[bucket];
		key_rd_q <= keys_mem[rd_addr];
		klen_rd_q <= klen_mem[rd_addr];
		val_rd_q <= vals_mem[rd_addr];
		vlen_rd_q <= vlen_mem[rd_addr];
		link_rd_q <= link_mem[rd_addr];
		if (link_we) link_mem[wr_addr] <= link_wd;
		if (ent_we) begin
			keys_mem[wr_addr] <= key;
			klen_mem[wr_addr] <= len;
			vals_mem[wr_addr] <= VALUE_WIDTH'(value);
			vlen_mem[wr_addr] <= value_len;
		end
		if (st_q == C_INS) heads_mem[bkt_q] <= free_q;
		if (st_q == C_DEL && prev_q == NIL) heads_mem[bkt_q] <= link_rd_q;
	end

	// memory address and write selection
	always_comb begin
		rd_addr = AW'(cur_q);
		wr_addr = AW'(cur_q);
		link_we = 1'b0;
		ent_we = 1'b0;
		link_wd = link_rd_q;
		case (st_q)
			C_INIT: begin
				wr_addr = AW'(init_q);
				link_we = 1'b1;
				link_wd = EW'(init_q) + EW'(1);
			end
			C_HEAD: rd_addr = AW'(head_val);
			C_CMP: rd_addr = AW'(link_rd_q);
			C_INS: begin
				wr_addr = AW'(free_q);
				link_we = 1'b1;
				ent_we = 1'b1;
				link_wd = head_val;
			end
			C_DEL: begin
				wr_addr = AW'(prev_q);
				link_we = (prev_q != NIL);
			end
			C_FREE: begin
				wr_addr = AW'(hit_q);
				link_we = 1'b1;
				link_wd = free_q;
			end
			// delete needs the link of the hit, insert the link of the free slot
			C_RD: rd_addr = (cmd == CMD_DELETE) ? AW'(hit_q) : AW'(free_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_INIT;
			init_q <= '0;
			head_vld_q <= '0;
			free_q <= '0;
			bkt_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			hit_q <= '0;
			steps_q <= '0;
			sts_q <= ST_OK;
			fv_q <= '0;
			fl_q <= '0;
		end else begin
			case (st_q)
				C_INIT: begin
					init_q <= init_q + SW'(1);
					if (init_q == SW'(MAX_ENTRIES - 1)) st_q <= C_IDLE;
				end
				C_IDLE: if (start) st_q <= C_HASH;
				C_HASH: begin
					if (hash_done) begin
						bkt_q <= bucket;
						st_q <= C_HEAD;
					end
				end
				C_HEAD: begin
					cur_q <= head_val;
					prev_q <= NIL;
					hit_q <= NIL;
					steps_q <= '0;
					fv_q <= '0;
					fl_q <= '0;
					st_q <= C_CMP;
				end
				C_CMP: begin
					// entry read data for cur_q is valid here
					if (cur_q == NIL || steps_q == NIL) begin
						st_q <= C_RD;
					end else if (klen_rd_q == len && key_rd_q == key) begin
						hit_q <= cur_q;
						if (cmd == CMD_SEARCH) begin
							fv_q <= ValW'(val_rd_q);
							fl_q <= vlen_rd_q;
						end
						st_q <= C_RD;
					end else begin
						prev_q <= cur_q;
						cur_q <= link_rd_q;
						steps_q <= steps_q + EW'(1);
					end
				end
				C_RD: begin
					case (cmd)
						CMD_INSERT: begin
							if (hit_q != NIL) begin
								sts_q <= ST_DUP;
								st_q <= C_OUT;
							end else if (free_q == NIL) begin
								sts_q <= ST_FULL;
								st_q <= C_OUT;
							end else begin
								sts_q <= ST_OK;
								st_q <= C_INS;
							end
						end
						CMD_DELETE: begin
							sts_q <= (hit_q != NIL) ? ST_OK : ST_NOTFOUND;
							st_q <= (hit_q != NIL) ? C_DEL : C_OUT;
						end
						CMD_SEARCH: begin
							sts_q <= (hit_q != NIL) ? ST_OK : ST_NOTFOUND;
							st_q <= C_OUT;
						end
						default: begin
							sts_q <= ST_NOTFOUND;
							st_q <= C_OUT;
						end
					endcase
				end
				C_INS: begin
					// link_rd_q holds link of free slot (read in C_RD)
					free_q <= link_rd_q;
					head_vld_q[bkt_q] <= 1'b1;
					st_q <= C_OUT;
				end
				C_DEL: st_q <= C_FREE;
				C_FREE: begin
					free_q <= hit_q;
					st_q <= C_OUT;
				end
				C_OUT: st_q <= C_IDLE;
				default: st_q <= C_IDLE;
			endcase
		end
	end
endmodule

/* design/chained_hash_table_engine.sv */
// a word is registered, hashed one key byte at a time, then its bucket head is read and
// its chain compared entry by entry; an insert then stores and a delete unlinks and frees.
// one word at a time: the next word is taken the cycle after the result is taken,
// paced by the byte-serial hash reduction and the one-read-per-cycle entry memory
// reset: asynchronous, active low; table_size returns to 256 and all buckets empty
// after reset the free list is built one entry per cycle, input stalled
`include "assert_macros.svh"
module chained_hash_table_engine #(
	parameter int NUM_BUCKETS = cht_pkg::NumBucketsDef,
	parameter int MAX_ENTRIES = cht_pkg::MaxEntriesDef,
	parameter int KEY_BYTES = cht_pkg::KeyBytesDef,
	parameter int VALUE_WIDTH = cht_pkg::ValueWidthDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [cht_pkg::CfgW-1:0]  cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                cmd,
	input  logic [cht_pkg::KeyW-1:0]  key,
	input  logic [cht_pkg::KlenW-1:0] key_len,
	input  logic [cht_pkg::ValW-1:0]  value,
	input  logic [cht_pkg::VlenW-1:0] value_len,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [cht_pkg::ValW-1:0]  found_value,
	output logic [cht_pkg::VlenW-1:0] found_len
);
	import cht_pkg::*;

	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int EW = $clog2(MAX_ENTRIES + 1);

	logic [CfgW-1:0] tsize_q;
	logic [16:0] modv;
	logic [1:0] cmd_q;
	logic [KeyW-1:0] key_q;
	logic [3:0] len_q;
	logic [ValW-1:0] val_q;
	logic [VlenW-1:0] vlen_q;
	logic busy_q, core_busy, res_valid, hdone, init_done, accept;
	logic [BW-1:0] bucket;
	logic [1:0] rs;
	logic [ValW-1:0] rv;
	logic [VlenW-1:0] rl;
	logic [3:0] len_c;
	logic [KeyW-1:0] kmask;

	always_comb begin
		modv = 17'(tsize_q);
		if (tsize_q == '0) modv = 17'd1;
		if (32'(tsize_q) > NUM_BUCKETS) modv = 17'(NUM_BUCKETS);
		len_c = (key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_len;
		kmask = (len_c >= 4'd8) ? '1 : ((KeyW'(1) << {len_c[2:0], 3'b000}) - KeyW'(1));
	end

	assign in_stall = busy_q || !init_done;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= CfgW'(256);
			busy_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) tsize_q <= cfg_wdata;
			if (accept) busy_q <= 1'b1;
			if (res_valid) out_valid <= 1'b1;
			else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			key_q <= key & kmask;
			len_q <= len_c;
			val_q <= value;
			vlen_q <= value_len;
		end
		if (res_valid) begin
			status <= rs;
			found_value <= rv;
			found_len <= rl;
		end
	end

	logic go_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) go_q <= 1'b0;
		else go_q <= accept;
	end

	cht_hash #(.NUM_BUCKETS(NUM_BUCKETS), .KEY_BYTES(KEY_BYTES), .BW(BW)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(go_q), .key(key_q), .len(len_q),
		.modv(modv), .done(hdone), .bucket(bucket)
	);

	cht_core #(.NUM_BUCKETS(NUM_BUCKETS), .MAX_ENTRIES(MAX_ENTRIES),
		.VALUE_WIDTH(VALUE_WIDTH), .BW(BW), .EW(EW)) u_core (
		.clk(clk), .arst_n(arst_n), .start(go_q), .cmd(cmd_q), .key(key_q),
		.len(len_q), .value(val_q), .value_len(vlen_q), .hash_done(hdone),
		.bucket(bucket), .busy(core_busy), .res_valid(res_valid), .res_status(rs),
		.res_value(rv), .res_len(rl), .init_done(init_done)
	);

	`CHT_ASSERT(a_res_busy, clk, arst_n, res_valid |-> busy_q, "result without word")
	`CHT_ASSERT(a_out_one, clk, arst_n, res_valid |=> out_valid, "result not presented")
	`CHT_ASSERT(a_go_idle, clk, arst_n, go_q |-> !core_busy, "start while core busy")
	`CHT_ASSERT_RST(a_rst_out, clk, !arst_n |-> !out_valid, "valid during reset")
endmodule
